>>> design/cqr_pkg.sv
package cqr_pkg;

  localparam int DEPTH = 128;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_ENQ = 2'd0;
  localparam op_t OP_DEQ = 2'd1;
  localparam op_t OP_REV = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  typedef logic [AW-1:0] addr_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input transfer, latch result kind
    logic enq_wr;     // write value at tail
    logic deq_rd;     // read at head
    logic rev_ld;     // load reverse pointers
    logic swp_rd;     // read both ends of the pair
    logic swp_wr_lo;  // low slot <= high word
    logic swp_wr_hi;  // high slot <= low word, step pointers
    logic load_out;   // move result to output register
  } cqr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rev_short;  // fewer than two entries
    logic last_pair;
    logic out_free;
  } cqr_stat_t;

endpackage

>>> design/cqr_ctrl.sv
module cqr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  cqr_pkg::op_t        op,
  input  cqr_pkg::cqr_stat_t  stat,
  output cqr_pkg::cqr_cmd_t   cmd
);
  import cqr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRD  = 5'b00010,
    S_SWL  = 5'b00100,
    S_SWH  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          case (op)
            OP_ENQ:  cmd.enq_wr = !stat.full;
            OP_DEQ:  cmd.deq_rd = !stat.empty;
            OP_REV:  cmd.rev_ld = 1'b1;
            default: ;
          endcase
          state_nxt = (op == OP_REV && !stat.rev_short) ? S_SRD : S_RESP;
        end
      end
      S_SRD: begin
        cmd.swp_rd = 1'b1;
        state_nxt  = S_SWL;
      end
      S_SWL: begin
        cmd.swp_wr_lo = 1'b1;
        state_nxt     = S_SWH;
      end
      S_SWH: begin
        cmd.swp_wr_hi = 1'b1;
        state_nxt     = stat.last_pair ? S_RESP : S_SRD;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a swap pass only starts with at least one pair to swap
  a_rev_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rev_ld && !stat.rev_short |=> state_r == S_SRD)
    else $error("reverse did not start swap pass");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r != S_IDLE)
    else $error("item accepted without producing a result");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && !stat.out_free |=> state_r == S_RESP)
    else $error("result dropped while output busy");

endmodule

>>> design/cqr_dp.sv
module cqr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cqr_pkg::cqr_cmd_t   cmd,
  output cqr_pkg::cqr_stat_t  stat,
  input  cqr_pkg::op_t        op,
  input  logic signed [31:0]  value_in,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic signed [31:0]  value_out,
  output cqr_pkg::status_t    status
);
  import cqr_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  addr_t         head_r, tail_r, lo_r, hi_r;
  addr_t         count;
  addr_t         pairs_r;
  logic [DW-1:0] rd_a_r, rd_b_r;
  status_t       res_status_r;
  logic          res_ram_r, res_neg_r;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  status_t       out_status_r;

  logic          wr_en;
  addr_t         wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_a_en;
  addr_t         rd_a_addr;

  assign count = tail_r - head_r;

  assign stat.empty     = (head_r == tail_r);
  assign stat.full      = (addr_t'(tail_r + 1'b1) == head_r);
  assign stat.rev_short = (count[AW-1:1] == '0);
  assign stat.last_pair = (pairs_r == addr_t'(1));
  assign stat.out_free  = !out_valid_r || out_tready;

  always_comb begin
    wr_en   = cmd.enq_wr || cmd.swp_wr_lo || cmd.swp_wr_hi;
    wr_addr = tail_r;
    wr_data = value_in;
    if (cmd.swp_wr_lo) begin
      wr_addr = lo_r;
      wr_data = rd_b_r;
    end else if (cmd.swp_wr_hi) begin
      wr_addr = hi_r;
      wr_data = rd_a_r;
    end
    rd_a_en   = cmd.deq_rd || cmd.swp_rd;
    rd_a_addr = cmd.swp_rd ? lo_r : head_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (cmd.swp_rd) begin
      rd_b_r <= mem[hi_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cmd.enq_wr) begin
        tail_r <= tail_r + 1'b1;
      end
      if (cmd.deq_rd) begin
        head_r <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rev_ld) begin
      lo_r    <= head_r;
      hi_r    <= tail_r - 1'b1;
      pairs_r <= count >> 1;
    end else if (cmd.swp_wr_hi) begin
      lo_r    <= lo_r + 1'b1;
      hi_r    <= hi_r - 1'b1;
      pairs_r <= pairs_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_ram_r    <= (op == OP_DEQ) && !stat.empty;
      res_neg_r    <= (op == OP_DEQ) && stat.empty;
      res_status_r <= ((op == OP_ENQ) && stat.full)  ? ST_OVERFLOW  :
                      ((op == OP_DEQ) && stat.empty) ? ST_UNDERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= res_ram_r ? rd_a_r : (res_neg_r ? '1 : '0);
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign value_out  = out_value_r;
  assign status     = out_status_r;

  a_no_ovr_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_wr |-> !stat.full)
    else $error("write into a full queue");

  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swp_wr_lo |-> lo_r != hi_r && pairs_r != '0)
    else $error("swap pass ran past the middle");

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("pending result overwritten");

  a_rev_keeps_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swp_rd || cmd.swp_wr_lo || cmd.swp_wr_hi |=> $stable(head_r) && $stable(tail_r))
    else $error("queue pointers moved during reverse");

endmodule

>>> design/circular_queue_with_reverse_unit.sv
// Channel   Dir  Ports                      Contents
// in_       in   tvalid tready tdata tuser  value_in, operation
// out_      out  tvalid tready tdata tuser  value_out, status
//
// Enqueue and dequeue each take an accept in the idle state plus a result load.
// Reverse swaps floor(count/2) pairs before its result load: one read and two writes per
// swapped pair on the single write port of the 128-word store.
// Reset clears the head and tail pointers and the FSM; store contents stay.
// A result waiting on out_tready holds the unit in its result state.
module circular_queue_with_reverse_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic signed [31:0]  in_tdata,   // [31:0] value_in
  input  logic [1:0]          in_tuser,   // [1:0] operation
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic signed [31:0]  out_tdata,  // [31:0] value_out
  output logic [1:0]          out_tuser   // [1:0] status
);
  import cqr_pkg::*;

  cqr_cmd_t  cmd;
  cqr_stat_t stat;

  cqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  cqr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .op         (in_tuser),
    .value_in   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .value_out  (out_tdata),
    .status     (out_tuser)
  );

endmodule
